@@ hw/rtl/gbp_pkg.sv @@
`timescale 1ns / 1ps

package gbp_pkg;

  // Width of the global branch history register.
  localparam int unsigned HIST_W = 8;

  // Command codes carried on command_i.
  localparam logic CMD_PREDICT = 1'b0;
  localparam logic CMD_UPDATE  = 1'b1;

  localparam logic [63:0] INSTR_BYTES    = 64'd4;
  localparam logic [1:0]  COUNTER_MAX    = 2'd3;
  localparam logic [1:0]  COUNTER_MIN    = 2'd0;
  localparam logic [1:0]  TAKE_THRESHOLD = 2'd2;

  // One entry of the branch target buffer as it is kept in memory.
  typedef struct packed {
    logic        valid;
    logic        cond;
    logic [63:0] tag;
    logic [63:0] target;
  } btb_line_t;

  localparam int unsigned BTB_ENTRY_W = $bits(btb_line_t);

endpackage

@@ hw/rtl/gbp_ram.sv @@
`timescale 1ns / 1ps

module gbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/gshare_btb_branch_predictor.sv @@
`timescale 1ns / 1ps

// Gshare branch predictor with a direct-mapped branch target buffer.
//
// A word is offered on the command ports and taken at a rising edge where
// start_i is high and busy_o is low. command_i selects a prediction (next
// fetch pc) or an update (resolved branch outcome, trains the tables).
// Exactly one result word follows each command: it is shown on the result
// ports, marked by result_valid_o, for the one cycle that begins at the edge
// after the one that took the command, and is taken at the edge that ends
// that cycle. The receiver cannot stall, so a result is never held.
// The block takes a new word only once it is through with the last one: the
// buffer and the counter table sit in synchronous RAMs with a registered read,
// and each word is first read, then forms its result and writes back. A new
// word may be taken in the same cycle as the previous result is shown.
// After reset a clearing pass runs over both RAMs, one entry per cycle, over
// max(BTB_ENTRIES, COUNTER_ENTRIES) entries (1024 at the default sizes) with
// busy_o high. Both table sizes must be powers of two; nothing checks this.
module gshare_btb_branch_predictor #(
  parameter int unsigned BTB_ENTRIES     = 1024,
  parameter int unsigned COUNTER_ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        command_i,
  input  logic [63:0] pc_i,
  input  logic [63:0] actual_next_pc_i,
  input  logic [63:0] predicted_next_pc_i,
  input  logic        predicted_taken_i,
  input  logic        fetch_btb_hit_i,
  input  logic        is_conditional_i,
  input  logic        taken_i,
  output logic        result_valid_o,
  output logic [63:0] next_pc_o,
  output logic        took_target_o,
  output logic        btb_hit_o,
  output logic        mispredict_o
);

  import gbp_pkg::*;

  localparam int unsigned BTB_IDX_W = $clog2(BTB_ENTRIES);
  localparam int unsigned CTR_IDX_W = $clog2(COUNTER_ENTRIES);
  localparam int unsigned CLR_DEPTH =
    (BTB_ENTRIES > COUNTER_ENTRIES) ? BTB_ENTRIES : COUNTER_ENTRIES;
  localparam int unsigned CLR_W = $clog2(CLR_DEPTH);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  state_e state_q, state_d;
  logic [CLR_W-1:0]  clr_q, clr_d;
  logic [HIST_W-1:0] hist_q, hist_d;
  logic              res_valid_q, res_valid_d;
  logic [63:0]       res_next_pc_q, res_next_pc_d;
  logic              res_took_q, res_took_d;
  logic              res_hit_q, res_hit_d;
  logic              res_miss_q, res_miss_d;

  // Command word held while its lookup is under way.
  logic                 cmd_q, cmd_d;
  logic [63:0]          pc_q, pc_d;
  logic [63:0]          anpc_q, anpc_d;
  logic [63:0]          pnpc_q, pnpc_d;
  logic                 ptaken_q, ptaken_d;
  logic                 fhit_q, fhit_d;
  logic                 cond_q, cond_d;
  logic                 taken_q, taken_d;
  logic [CTR_IDX_W-1:0] cidx_q, cidx_d;

  logic                 accept;
  logic [61:0]          cmix;
  logic [CTR_IDX_W-1:0] cidx_in;
  logic [BTB_IDX_W-1:0] bidx_in;

  logic                 btb_we;
  logic [BTB_IDX_W-1:0] btb_waddr;
  btb_line_t            btb_wdata;
  btb_line_t            btb_rdata;
  logic [BTB_ENTRY_W-1:0] btb_rbits;

  logic                 ctr_we;
  logic [CTR_IDX_W-1:0] ctr_waddr;
  logic [1:0]           ctr_wdata;
  logic [1:0]           ctr_rdata;

  logic                 lk_hit;
  logic                 lk_use_target;
  logic                 lk_update;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;

  // Buffer slot is pc bits above the instruction offset; the counter slot
  // folds the global history into the same bits.
  assign bidx_in = pc_i[BTB_IDX_W+1:2];
  assign cmix    = pc_i[63:2] ^ {{(62-HIST_W){1'b0}}, hist_q};
  assign cidx_in = cmix[CTR_IDX_W-1:0];

  assign btb_rdata = btb_line_t'(btb_rbits);

  gbp_ram #(
    .WIDTH(BTB_ENTRY_W),
    .DEPTH(BTB_ENTRIES)
  ) u_btb_ram (
    .clk_i  (clk_i),
    .we_i   (btb_we),
    .waddr_i(btb_waddr),
    .wdata_i(btb_wdata),
    .re_i   (accept),
    .raddr_i(bidx_in),
    .rdata_o(btb_rbits)
  );

  gbp_ram #(
    .WIDTH(2),
    .DEPTH(COUNTER_ENTRIES)
  ) u_ctr_ram (
    .clk_i  (clk_i),
    .we_i   (ctr_we),
    .waddr_i(ctr_waddr),
    .wdata_i(ctr_wdata),
    .re_i   (accept),
    .raddr_i(cidx_in),
    .rdata_o(ctr_rdata)
  );

  // Lookup results, valid in the cycle after the read was issued. The write
  // of an update lands before the next word's read, so no forwarding is
  // needed.
  assign lk_hit        = btb_rdata.valid && (btb_rdata.tag == pc_q);
  assign lk_use_target = lk_hit && (!btb_rdata.cond || (ctr_rdata >= TAKE_THRESHOLD));
  assign lk_update     = (state_q == ST_LOOKUP) && (cmd_q == CMD_UPDATE);

  always_comb begin
    btb_we    = 1'b0;
    btb_waddr = pc_q[BTB_IDX_W+1:2];
    btb_wdata = '{valid: 1'b1, cond: cond_q, tag: pc_q, target: anpc_q};
    ctr_we    = 1'b0;
    ctr_waddr = cidx_q;
    ctr_wdata = ctr_rdata;

    if (state_q == ST_CLEAR) begin
      // Sizes are powers of two, so the smaller table simply wraps.
      btb_we    = 1'b1;
      btb_waddr = clr_q[BTB_IDX_W-1:0];
      btb_wdata = '0;
      ctr_we    = 1'b1;
      ctr_waddr = clr_q[CTR_IDX_W-1:0];
      ctr_wdata = COUNTER_MIN;
    end else if (lk_update) begin
      btb_we = taken_q;
      ctr_we = cond_q;
      if (taken_q) begin
        ctr_wdata = (ctr_rdata == COUNTER_MAX) ? ctr_rdata : ctr_rdata + 2'd1;
      end else begin
        ctr_wdata = (ctr_rdata == COUNTER_MIN) ? ctr_rdata : ctr_rdata - 2'd1;
      end
    end
  end

  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    hist_d        = hist_q;
    res_valid_d   = 1'b0;
    res_next_pc_d = res_next_pc_q;
    res_took_d    = res_took_q;
    res_hit_d     = res_hit_q;
    res_miss_d    = res_miss_q;
    cmd_d         = cmd_q;
    pc_d          = pc_q;
    anpc_d        = anpc_q;
    pnpc_d        = pnpc_q;
    ptaken_d      = ptaken_q;
    fhit_d        = fhit_q;
    cond_d        = cond_q;
    taken_d       = taken_q;
    cidx_d        = cidx_q;

    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + CLR_W'(1);
        if (clr_q == CLR_W'(CLR_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_d    = command_i;
          pc_d     = pc_i;
          anpc_d   = actual_next_pc_i;
          pnpc_d   = predicted_next_pc_i;
          ptaken_d = predicted_taken_i;
          fhit_d   = fetch_btb_hit_i;
          cond_d   = is_conditional_i;
          taken_d  = taken_i;
          cidx_d   = cidx_in;
          state_d  = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        res_valid_d = 1'b1;
        state_d     = ST_IDLE;
        if (cmd_q == CMD_PREDICT) begin
          res_next_pc_d = lk_use_target ? btb_rdata.target : pc_q + INSTR_BYTES;
          res_took_d    = lk_use_target;
          res_hit_d     = lk_hit;
          res_miss_d    = 1'b0;
        end else begin
          res_next_pc_d = anpc_q;
          res_took_d    = 1'b0;
          res_hit_d     = fhit_q;
          res_miss_d    = (anpc_q != pnpc_q) || (ptaken_q != taken_q) ||
                          (taken_q && !fhit_q);
          if (cond_q) begin
            hist_d = {hist_q[HIST_W-2:0], taken_q};
          end
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_q         <= '0;
      hist_q        <= '0;
      res_valid_q   <= 1'b0;
      res_next_pc_q <= '0;
      res_took_q    <= 1'b0;
      res_hit_q     <= 1'b0;
      res_miss_q    <= 1'b0;
      cmd_q         <= CMD_PREDICT;
      pc_q          <= '0;
      anpc_q        <= '0;
      pnpc_q        <= '0;
      ptaken_q      <= 1'b0;
      fhit_q        <= 1'b0;
      cond_q        <= 1'b0;
      taken_q       <= 1'b0;
      cidx_q        <= '0;
    end else begin
      state_q       <= state_d;
      clr_q         <= clr_d;
      hist_q        <= hist_d;
      res_valid_q   <= res_valid_d;
      res_next_pc_q <= res_next_pc_d;
      res_took_q    <= res_took_d;
      res_hit_q     <= res_hit_d;
      res_miss_q    <= res_miss_d;
      cmd_q         <= cmd_d;
      pc_q          <= pc_d;
      anpc_q        <= anpc_d;
      pnpc_q        <= pnpc_d;
      ptaken_q      <= ptaken_d;
      fhit_q        <= fhit_d;
      cond_q        <= cond_d;
      taken_q       <= taken_d;
      cidx_q        <= cidx_d;
    end
  end

  assign result_valid_o = res_valid_q;
  assign next_pc_o      = res_next_pc_q;
  assign took_target_o  = res_took_q;
  assign btb_hit_o      = res_hit_q;
  assign mispredict_o   = res_miss_q;

  // A result only ever follows a lookup cycle.
  a_result_after_lookup: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == ST_LOOKUP)
  ) else $error("result strobe without a preceding lookup");

  // A taken command always moves into the lookup cycle.
  a_accept_to_lookup: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_LOOKUP)
  ) else $error("accepted word did not enter lookup");

  // The history only shifts when an update is resolved.
  a_hist_stable: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_LOOKUP) |=> $stable(hist_q)
  ) else $error("history changed outside an update");

  // Neither a result nor a RAM write from an update may overlap the clearing pass.
  a_no_result_in_clear: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !result_valid_o && !lk_update
  ) else $error("activity during clearing pass");

  // A prediction that takes its target never reports a misprediction.
  a_predict_no_miss: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && took_target_o) |-> !mispredict_o
  ) else $error("prediction flagged a misprediction");

endmodule
